>>> hdl/ppi_pkg.sv
// shared types, constants and the quarter-wave sine generator of the pose integrator
package ppi_pkg;

  localparam int unsigned VEL_W   = 24;
  localparam int unsigned STEP_W  = 24;
  localparam int unsigned POS_W   = 40;
  localparam int unsigned HEAD_W  = 16;
  localparam int unsigned ANG_W   = 32;
  localparam int unsigned SINE_W  = 17;

  localparam int unsigned STATE_DEPTH = 6;

  localparam logic [POS_W-1:0] POS_RESET = 40'd65536;
  localparam logic [POS_W-1:0] POS_MAX   = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0] POS_MIN   = {1'b1, {(POS_W-1){1'b0}}};

  localparam logic [63:0] HALF_PI_Q30    = 64'h6487ED51;
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

  // denominators of the sine series terms, (2k)(2k+1)
  localparam logic [63:0] TAYLOR_DIV [7] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
  };

  // transaction kinds
  typedef enum logic {
    KIND_SET_VEL = 1'b0,
    KIND_STEP    = 1'b1
  } ppi_kind_e;

  // entries of the state memory
  typedef enum logic [2:0] {
    ENT_X  = 3'd0,
    ENT_Y  = 3'd1,
    ENT_H  = 3'd2,
    ENT_VX = 3'd3,
    ENT_VY = 3'd4,
    ENT_WR = 3'd5
  } ppi_entry_e;

  typedef struct packed {
    ppi_entry_e       raddr;
    logic             we;
    ppi_entry_e       waddr;
    logic [POS_W-1:0] wdata;
  } mem_req_t;

  // sin(idx / 2^bits * pi/2) in Q1.16 from a Q30 series, rounded half up
  function automatic logic [SINE_W-1:0] sine_entry(input int unsigned idx,
                                                   input int unsigned bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    logic [63:0] r;
    x    = (HALF_PI_Q30 * 64'(idx)) >> bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
      if ((k & 1) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (64'(sum) + 64'd8192) >> 14;
    if (r > 64'd65536) begin
      r = 64'd65536;
    end
    return r[SINE_W-1:0];
  endfunction

endpackage

>>> hdl/ppi_if.sv
// stream interfaces of the pose integrator: command input and pose output
interface ppi_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [ppi_pkg::VEL_W-1:0]    lin_vel_x;
  logic signed [ppi_pkg::VEL_W-1:0]    lin_vel_y;
  logic signed [ppi_pkg::VEL_W-1:0]    turn_rate;
  logic        [ppi_pkg::STEP_W-1:0]   step_time;

  modport source (output valid, kind, lin_vel_x, lin_vel_y, turn_rate, step_time,
                  input ready);
  modport sink   (input valid, kind, lin_vel_x, lin_vel_y, turn_rate, step_time,
                  output ready);
endinterface

interface ppi_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ppi_pkg::POS_W-1:0]    pos_x;
  logic signed [ppi_pkg::POS_W-1:0]    pos_y;
  logic        [ppi_pkg::HEAD_W-1:0]   heading;
  logic                                saturated;

  modport source (output valid, pos_x, pos_y, heading, saturated, input ready);
  modport sink   (input valid, pos_x, pos_y, heading, saturated, output ready);
endinterface

>>> hdl/ppi_state_mem.sv
// pose and velocity state memory: one write port, one registered read port
module ppi_state_mem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ppi_pkg::mem_req_t           req_i,
  output logic [ppi_pkg::POS_W-1:0]   rdata_o
);

  logic [ppi_pkg::POS_W-1:0]       mem_q [ppi_pkg::STATE_DEPTH];
  logic [ppi_pkg::STATE_DEPTH-1:0] vld_q;
  logic [ppi_pkg::POS_W-1:0]       rdata_q;
  logic [ppi_pkg::POS_W-1:0]       reset_word;

  // unwritten entries read as their reset value
  always_comb begin
    unique case (req_i.raddr)
      ppi_pkg::ENT_X, ppi_pkg::ENT_Y: reset_word = ppi_pkg::POS_RESET;
      default:                        reset_word = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= vld_q[req_i.raddr] ? mem_q[req_i.raddr] : reset_word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.we) begin
      vld_q[req_i.waddr] <= 1'b1;
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/ppi_sine_rom.sv
// quarter-wave sine table rom with registered read
module ppi_sine_rom #(
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic                         clk_i,
  input  logic [SINE_TABLE_BITS:0]     addr_i,
  output logic [ppi_pkg::SINE_W-1:0]   rdata_o
);

  localparam int unsigned TAB_N = 1 << SINE_TABLE_BITS;

  typedef logic [ppi_pkg::SINE_W-1:0] tab_t [TAB_N+1];

  function automatic tab_t build_tab();
    tab_t t;
    for (int unsigned i = 0; i <= TAB_N; i++) begin
      t[i] = ppi_pkg::sine_entry(i, SINE_TABLE_BITS);
    end
    return t;
  endfunction

  localparam tab_t SINE_TAB = build_tab();

  logic [ppi_pkg::SINE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    rdata_q <= SINE_TAB[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/ppi_mul.sv
// shared signed multiplier with registered product
module ppi_mul (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [30:0] b_i,
  output logic signed [63:0] p_o
);

  logic signed [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

>>> hdl/planar_pose_integrator_unit.sv
// top level of the dead-reckoning pose integrator: sequencer and datapath
//
//  channel | direction | transaction carries
//  --------+-----------+------------------------------------------------
//  in_i    | sink      | kind, lin_vel_x, lin_vel_y, turn_rate, step_time
//  out_o   | source    | pos_x, pos_y, heading, saturated
//
// a velocity command runs through states V0 to V3, a pose step through P0 to P15,
// both then DONE, and no new item is taken before IDLE; the single read port of the
// state memory and the one shared multiplier set the step sequence.
// reset returns all pose and velocity state to its reset value through the memory valid bits.
// a finished result waits in the output register; a following item is taken
// meanwhile and holds in its final state only if that register is still full.
module planar_pose_integrator_unit #(
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ppi_in_if.sink       in_i,
  ppi_out_if.source    out_o
);

  localparam int unsigned AW = SINE_TABLE_BITS + 1;
  localparam logic [AW-1:0] TAB_N_A = AW'(1) << SINE_TABLE_BITS;

  typedef enum logic [4:0] {
    ST_IDLE, ST_V0, ST_V1, ST_V2, ST_V3,
    ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7,
    ST_P8, ST_P9, ST_P10, ST_P11, ST_P12, ST_P13, ST_P14, ST_P15,
    ST_DONE
  } state_e;

  state_e state_q;

  // latched transaction
  logic                               in_kind_q;
  logic signed [ppi_pkg::VEL_W-1:0]   in_vx_q;
  logic signed [ppi_pkg::VEL_W-1:0]   in_vy_q;
  logic signed [ppi_pkg::VEL_W-1:0]   in_wr_q;
  logic        [ppi_pkg::STEP_W-1:0]  in_dt_q;

  // working registers
  logic        [ppi_pkg::ANG_W-1:0]   ang_q;
  logic signed [ppi_pkg::VEL_W-1:0]   vx_q;
  logic signed [ppi_pkg::VEL_W-1:0]   vy_q;
  logic signed [ppi_pkg::VEL_W-1:0]   wr_q;
  logic        [ppi_pkg::SINE_W-1:0]  a_q;
  logic signed [17:0]                 s_q;
  logic signed [17:0]                 c_q;
  logic signed [ppi_pkg::POS_W-1:0]   px_q;
  logic signed [ppi_pkg::POS_W-1:0]   py_q;
  logic signed [63:0]                 acc_q;
  logic signed [25:0]                 wx_q;
  logic signed [25:0]                 wy_q;
  logic        [46:0]                 mag_q;
  logic                               neg_q;
  logic                               sat_q;

  // output register
  logic                               out_valid_q;
  logic signed [ppi_pkg::POS_W-1:0]   out_x_q;
  logic signed [ppi_pkg::POS_W-1:0]   out_y_q;
  logic        [ppi_pkg::HEAD_W-1:0]  out_h_q;
  logic                               out_sat_q;

  ppi_pkg::mem_req_t                  mem_req;
  logic [ppi_pkg::POS_W-1:0]          mem_rdata;
  logic [AW-1:0]                      rom_addr;
  logic [ppi_pkg::SINE_W-1:0]         rom_rdata;
  logic signed [32:0]                 mul_a;
  logic signed [30:0]                 mul_b;
  logic signed [63:0]                 prod;

  logic [SINE_TABLE_BITS-1:0]         tab_idx;
  logic signed [17:0]                 sa;
  logic signed [17:0]                 sb;
  logic signed [17:0]                 s_n;
  logic signed [17:0]                 c_n;
  logic signed [63:0]                 rot_diff;
  logic signed [63:0]                 rot_sum;
  logic signed [ppi_pkg::POS_W-1:0]   pos_base;
  logic signed [ppi_pkg::POS_W:0]     pos_sum;
  logic                               pos_sat;
  logic signed [ppi_pkg::POS_W-1:0]   pos_new;
  logic signed [63:0]                 mag_full;
  logic [63:0]                        hd_sum;
  logic [ppi_pkg::ANG_W-1:0]          hd_inc;
  logic [ppi_pkg::ANG_W-1:0]          ang_new;

  ppi_state_mem u_state_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  ppi_sine_rom #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_sine_rom (
    .clk_i   (clk_i),
    .addr_i  (rom_addr),
    .rdata_o (rom_rdata)
  );

  ppi_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.pos_x     = out_x_q;
  assign out_o.pos_y     = out_y_q;
  assign out_o.heading   = out_h_q;
  assign out_o.saturated = out_sat_q;

  // table lookup, quadrant mirroring
  assign tab_idx = ang_q[29 -: SINE_TABLE_BITS];
  assign sa      = 18'($signed({1'b0, a_q}));
  assign sb      = 18'($signed({1'b0, rom_rdata}));

  always_comb begin
    unique case (ang_q[31:30])
      2'd0:    begin s_n = sa;  c_n = sb;  end
      2'd1:    begin s_n = sb;  c_n = -sa; end
      2'd2:    begin s_n = -sa; c_n = -sb; end
      default: begin s_n = -sb; c_n = sa;  end
    endcase
  end

  assign rot_diff = acc_q - prod;
  assign rot_sum  = acc_q + prod;

  // saturating position add
  assign pos_base = (state_q == ST_P11) ? py_q : px_q;
  assign pos_sum  = (ppi_pkg::POS_W+1)'(pos_base)
                  + (ppi_pkg::POS_W+1)'($signed(prod[49:16]));
  assign pos_sat  = pos_sum[ppi_pkg::POS_W] != pos_sum[ppi_pkg::POS_W-1];
  always_comb begin
    if (!pos_sat) begin
      pos_new = pos_sum[ppi_pkg::POS_W-1:0];
    end else if (pos_sum[ppi_pkg::POS_W]) begin
      pos_new = ppi_pkg::POS_MIN;
    end else begin
      pos_new = ppi_pkg::POS_MAX;
    end
  end

  // heading increment from |turn_rate * step| times 1/(2 pi)
  assign mag_full = prod[63] ? -prod : prod;
  assign hd_sum   = $unsigned(acc_q) + {16'b0, prod[63:16]};
  assign hd_inc   = hd_sum[47:16];
  assign ang_new  = neg_q ? (ang_q - hd_inc) : (ang_q + hd_inc);

  // memory, rom and multiplier control per step
  always_comb begin
    mem_req.raddr = ppi_pkg::ENT_X;
    mem_req.we    = 1'b0;
    mem_req.waddr = ppi_pkg::ENT_X;
    mem_req.wdata = '0;
    rom_addr      = {1'b0, tab_idx};
    mul_a         = '0;
    mul_b         = '0;
    unique case (state_q)
      ST_V0: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ppi_pkg::ENT_VX;
        mem_req.wdata = ppi_pkg::POS_W'(in_vx_q);
        mem_req.raddr = ppi_pkg::ENT_X;
      end
      ST_V1: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ppi_pkg::ENT_VY;
        mem_req.wdata = ppi_pkg::POS_W'(in_vy_q);
        mem_req.raddr = ppi_pkg::ENT_Y;
      end
      ST_V2: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ppi_pkg::ENT_WR;
        mem_req.wdata = ppi_pkg::POS_W'(in_wr_q);
        mem_req.raddr = ppi_pkg::ENT_H;
      end
      ST_P0: mem_req.raddr = ppi_pkg::ENT_H;
      ST_P1: mem_req.raddr = ppi_pkg::ENT_VX;
      ST_P2: mem_req.raddr = ppi_pkg::ENT_VY;
      ST_P3: begin
        mem_req.raddr = ppi_pkg::ENT_WR;
        rom_addr      = TAB_N_A - AW'(tab_idx);
      end
      ST_P4: mem_req.raddr = ppi_pkg::ENT_X;
      ST_P5: begin
        mem_req.raddr = ppi_pkg::ENT_Y;
        mul_a         = 33'(vx_q);
        mul_b         = 31'(c_q);
      end
      ST_P6: begin
        mul_a = 33'(vy_q);
        mul_b = 31'(s_q);
      end
      ST_P7: begin
        mul_a = 33'(vx_q);
        mul_b = 31'(s_q);
      end
      ST_P8: begin
        mul_a = 33'(vy_q);
        mul_b = 31'(c_q);
      end
      ST_P9: begin
        mul_a = 33'(wx_q);
        mul_b = $signed({7'b0, in_dt_q});
      end
      ST_P10: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ppi_pkg::ENT_X;
        mem_req.wdata = pos_new;
        mul_a         = 33'(wy_q);
        mul_b         = $signed({7'b0, in_dt_q});
      end
      ST_P11: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ppi_pkg::ENT_Y;
        mem_req.wdata = pos_new;
        mul_a         = 33'(wr_q);
        mul_b         = $signed({7'b0, in_dt_q});
      end
      ST_P13: begin
        mul_a = $signed({2'b0, mag_q[46:16]});
        mul_b = $signed({1'b0, ppi_pkg::INV_TWO_PI_Q32});
      end
      ST_P14: begin
        mul_a = $signed({17'b0, mag_q[15:0]});
        mul_b = $signed({1'b0, ppi_pkg::INV_TWO_PI_Q32});
      end
      ST_P15: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ppi_pkg::ENT_H;
        mem_req.wdata = {8'b0, ang_new};
      end
      default: begin
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        in_kind_q <= in_i.kind;
        in_vx_q   <= in_i.lin_vel_x;
        in_vy_q   <= in_i.lin_vel_y;
        in_wr_q   <= in_i.turn_rate;
        in_dt_q   <= in_i.step_time;
      end
      ST_V1:  px_q <= mem_rdata;
      ST_V2:  py_q <= mem_rdata;
      ST_V3: begin
        ang_q <= mem_rdata[ppi_pkg::ANG_W-1:0];
        sat_q <= 1'b0;
      end
      ST_P0:  sat_q <= 1'b0;
      ST_P1:  ang_q <= mem_rdata[ppi_pkg::ANG_W-1:0];
      ST_P2:  vx_q  <= mem_rdata[ppi_pkg::VEL_W-1:0];
      ST_P3: begin
        vy_q <= mem_rdata[ppi_pkg::VEL_W-1:0];
        a_q  <= rom_rdata;
      end
      ST_P4: begin
        wr_q <= mem_rdata[ppi_pkg::VEL_W-1:0];
        s_q  <= s_n;
        c_q  <= c_n;
      end
      ST_P5:  px_q  <= mem_rdata;
      ST_P6: begin
        py_q  <= mem_rdata;
        acc_q <= prod;
      end
      ST_P7:  wx_q  <= rot_diff[41:16];
      ST_P8:  acc_q <= prod;
      ST_P9:  wy_q  <= rot_sum[41:16];
      ST_P10: begin
        px_q  <= pos_new;
        sat_q <= sat_q | pos_sat;
      end
      ST_P11: begin
        py_q  <= pos_new;
        sat_q <= sat_q | pos_sat;
      end
      ST_P12: begin
        mag_q <= mag_full[46:0];
        neg_q <= prod[63];
      end
      ST_P14: acc_q <= prod;
      ST_P15: ang_q <= ang_new;
      default: begin
      end
    endcase
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_h_q     <= '0;
      out_sat_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            state_q <= (in_i.kind == ppi_pkg::KIND_STEP) ? ST_P0 : ST_V0;
          end
        end
        ST_V0:  state_q <= ST_V1;
        ST_V1:  state_q <= ST_V2;
        ST_V2:  state_q <= ST_V3;
        ST_V3:  state_q <= ST_DONE;
        ST_P0:  state_q <= ST_P1;
        ST_P1:  state_q <= ST_P2;
        ST_P2:  state_q <= ST_P3;
        ST_P3:  state_q <= ST_P4;
        ST_P4:  state_q <= ST_P5;
        ST_P5:  state_q <= ST_P6;
        ST_P6:  state_q <= ST_P7;
        ST_P7:  state_q <= ST_P8;
        ST_P8:  state_q <= ST_P9;
        ST_P9:  state_q <= ST_P10;
        ST_P10: state_q <= ST_P11;
        ST_P11: state_q <= ST_P12;
        ST_P12: state_q <= ST_P13;
        ST_P13: state_q <= ST_P14;
        ST_P14: state_q <= ST_P15;
        ST_P15: state_q <= ST_DONE;
        ST_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_x_q     <= px_q;
            out_y_q     <= py_q;
            out_h_q     <= ang_q[ppi_pkg::ANG_W-1 -: ppi_pkg::HEAD_W];
            out_sat_q   <= sat_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == ST_V0 || state_q == ST_P0))
    else $error("accepted transaction did not start a sequence");

  a_sat_only_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && sat_q) |-> (in_kind_q == ppi_pkg::KIND_STEP))
    else $error("saturation flagged on a velocity command");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result presented outside the final step");

  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !mem_req.we)
    else $error("state memory written while idle");

endmodule

>>> test/tb_top.sv
// self-checking testbench of the planar pose integrator with its own pose predictor
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned SINE_BITS     = 10;
  localparam int unsigned LUT_N         = 1 << SINE_BITS;
  localparam logic [63:0] QUARTER_Q30   = 64'h6487ED51;
  localparam logic [63:0] RAD_TO_BAM    = 64'd683565276;
  localparam longint      POS_HI        = 64'sd549755813887;
  localparam longint      POS_LO        = -64'sd549755813888;
  localparam int          HOLD_CYCLES   = 600;
  localparam int          SETTLE_CYCLES = 64;

  typedef struct {
    ppi_pkg::ppi_kind_e                 kind;
    logic signed [ppi_pkg::VEL_W-1:0]   vel_x;
    logic signed [ppi_pkg::VEL_W-1:0]   vel_y;
    logic signed [ppi_pkg::VEL_W-1:0]   turn;
    logic        [ppi_pkg::STEP_W-1:0]  dt;
  } pose_cmd_t;

  typedef struct {
    logic [ppi_pkg::POS_W-1:0]  pos_x;
    logic [ppi_pkg::POS_W-1:0]  pos_y;
    logic [ppi_pkg::HEAD_W-1:0] heading;
    logic                       saturated;
  } pose_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ppi_in_if  in_bus ();
  ppi_out_if out_bus ();

  planar_pose_integrator_unit #(
    .SINE_TABLE_BITS(SINE_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  int          sine_lut [0:LUT_N];
  longint      track_x = 65536;
  longint      track_y = 65536;
  logic [31:0] track_ang = '0;
  longint      held_vx = 0;
  longint      held_vy = 0;
  longint      held_turn = 0;

  pose_res_t   pose_queue [$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_seq = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  // quarter-wave sine in Q1.16 from a Q30 series, rounded half up
  initial begin
    logic [63:0] xa;
    logic [63:0] xsq;
    logic [63:0] term;
    longint      acc;
    longint      rnd;
    for (int i = 0; i <= LUT_N; i++) begin
      xa   = (QUARTER_Q30 * 64'(i)) >> SINE_BITS;
      xsq  = (xa * xa) >> 30;
      term = xa;
      acc  = longint'(xa);
      for (int k = 1; k <= 7; k++) begin
        term = ((term * xsq) >> 30) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      rnd = (acc + 8192) >>> 14;
      if (rnd > 65536) begin
        rnd = 65536;
      end
      sine_lut[i] = int'(rnd);
    end
  end

  function automatic pose_res_t advance_pose(input pose_cmd_t cmd);
    longint      sn;
    longint      cs;
    longint      lut_a;
    longint      lut_b;
    longint      wx;
    longint      wy;
    longint      dt;
    longint      nx;
    longint      ny;
    longint      prod;
    logic [63:0] mag;
    logic [63:0] q;
    int unsigned idx;
    pose_res_t   res;
    res.saturated = 1'b0;
    if (cmd.kind == ppi_pkg::KIND_SET_VEL) begin
      held_vx   = longint'(cmd.vel_x);
      held_vy   = longint'(cmd.vel_y);
      held_turn = longint'(cmd.turn);
    end else begin
      dt    = longint'({40'd0, cmd.dt});
      idx   = (track_ang >> (30 - SINE_BITS)) & (LUT_N - 1);
      lut_a = sine_lut[idx];
      lut_b = sine_lut[LUT_N - idx];
      case (track_ang[31:30])
        2'd0: begin sn = lut_a;  cs = lut_b;  end
        2'd1: begin sn = lut_b;  cs = -lut_a; end
        2'd2: begin sn = -lut_a; cs = -lut_b; end
        default: begin sn = -lut_b; cs = lut_a; end
      endcase
      wx = (held_vx * cs - held_vy * sn) >>> 16;
      wy = (held_vx * sn + held_vy * cs) >>> 16;
      nx = track_x + ((wx * dt) >>> 16);
      ny = track_y + ((wy * dt) >>> 16);
      if (nx > POS_HI) begin nx = POS_HI; res.saturated = 1'b1; end
      if (nx < POS_LO) begin nx = POS_LO; res.saturated = 1'b1; end
      if (ny > POS_HI) begin ny = POS_HI; res.saturated = 1'b1; end
      if (ny < POS_LO) begin ny = POS_LO; res.saturated = 1'b1; end
      track_x = nx;
      track_y = ny;
      // turn rate times step in Q.32 radians, scaled to a binary angle
      prod = held_turn * dt;
      mag  = (prod < 0) ? 64'(-prod) : 64'(prod);
      q    = (((mag >> 16) * RAD_TO_BAM) + (((mag & 64'hFFFF) * RAD_TO_BAM) >> 16)) >> 16;
      if (prod < 0) begin
        track_ang = track_ang - q[31:0];
      end else begin
        track_ang = track_ang + q[31:0];
      end
    end
    res.pos_x   = track_x[ppi_pkg::POS_W-1:0];
    res.pos_y   = track_y[ppi_pkg::POS_W-1:0];
    res.heading = track_ang[31:16];
    return res;
  endfunction

  function automatic pose_cmd_t make_cmd(input ppi_pkg::ppi_kind_e kind,
                                         input logic [23:0] vx,
                                         input logic [23:0] vy, input logic [23:0] wr,
                                         input logic [23:0] dt);
    pose_cmd_t cmd;
    cmd.kind  = kind;
    cmd.vel_x = vx;
    cmd.vel_y = vy;
    cmd.turn  = wr;
    cmd.dt    = dt;
    return cmd;
  endfunction

  function automatic logic [23:0] rand_vel();
    int t;
    case ($urandom_range(9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2, 3, 4: begin
        t = $urandom_range(131072);
        t = t - 65536;
        return t[23:0];
      end
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] rand_step();
    case ($urandom_range(9))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2, 3, 4, 5: return 24'($urandom_range(4096));
      default: return 24'($urandom);
    endcase
  endfunction

  // one input transaction; the expectation is formed when it is accepted
  task automatic send_cmd(input pose_cmd_t cmd);
    pose_res_t nxt;
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid     <= 1'b0;
      in_bus.kind      <= 1'($urandom);
      in_bus.lin_vel_x <= 24'($urandom);
      in_bus.lin_vel_y <= 24'($urandom);
      in_bus.turn_rate <= 24'($urandom);
      in_bus.step_time <= 24'($urandom);
      @(posedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.kind      <= cmd.kind;
    in_bus.lin_vel_x <= cmd.vel_x;
    in_bus.lin_vel_y <= cmd.vel_y;
    in_bus.turn_rate <= cmd.turn;
    in_bus.step_time <= cmd.dt;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    nxt = advance_pose(cmd);
    pose_queue.push_back(nxt);
  endtask

  task automatic wait_drain();
    in_bus.valid <= 1'b0;
    while (pose_queue.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_reset_state();
    // step before any velocity command, then a command that leaves the pose alone
    send_cmd(make_cmd(ppi_pkg::KIND_STEP, 24'($urandom), 24'($urandom), 24'($urandom),
                      24'hFFFFFF));
    send_cmd(make_cmd(ppi_pkg::KIND_SET_VEL, 24'd0, 24'd0, 24'd0, 24'hFFFFFF));
    send_cmd(make_cmd(ppi_pkg::KIND_STEP, 24'd0, 24'd0, 24'd0, 24'd65536));
  endtask

  task automatic test_field_extremes();
    send_cmd(make_cmd(ppi_pkg::KIND_SET_VEL, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'd0));
    send_cmd(make_cmd(ppi_pkg::KIND_STEP, 24'd0, 24'd0, 24'd0, 24'd0));
    send_cmd(make_cmd(ppi_pkg::KIND_STEP, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd1));
    send_cmd(make_cmd(ppi_pkg::KIND_STEP, 24'd0, 24'd0, 24'd0, 24'hFFFFFF));
    send_cmd(make_cmd(ppi_pkg::KIND_SET_VEL, 24'h800000, 24'h7FFFFF, 24'h800000,
                      24'hFFFFFF));
    send_cmd(make_cmd(ppi_pkg::KIND_STEP, 24'd0, 24'd0, 24'd0, 24'hFFFFFF));
    send_cmd(make_cmd(ppi_pkg::KIND_STEP, 24'd0, 24'd0, 24'd0, 24'hFFFFFF));
    send_cmd(make_cmd(ppi_pkg::KIND_SET_VEL, 24'hFFFFFF, 24'd1, 24'hFFFFFF, 24'd0));
    send_cmd(make_cmd(ppi_pkg::KIND_STEP, 24'd0, 24'd0, 24'd0, 24'hFFFFFF));
  endtask

  task automatic test_heading_wrap();
    // about a quarter turn per one-second step: visits every quadrant and wraps both ways
    send_cmd(make_cmd(ppi_pkg::KIND_SET_VEL, 24'h100000, 24'h030000, 24'd102944, 24'd0));
    repeat (5) send_cmd(make_cmd(ppi_pkg::KIND_STEP, 24'd0, 24'd0, 24'd0, 24'd65536));
    send_cmd(make_cmd(ppi_pkg::KIND_SET_VEL, 24'hF00000, 24'h020000, -24'sd102944, 24'd0));
    repeat (5) send_cmd(make_cmd(ppi_pkg::KIND_STEP, 24'd0, 24'd0, 24'd0, 24'd65536));
  endtask

  task automatic test_saturation();
    int     delta;
    longint steer;
    // steer the heading back near zero so the extreme velocities push along both axes
    delta = -$signed(track_ang);
    steer = longint'($rtoi(real'(delta) * 6.283185307179586 / 65536.0));
    send_cmd(make_cmd(ppi_pkg::KIND_SET_VEL, 24'd0, 24'd0, steer[23:0], 24'd0));
    send_cmd(make_cmd(ppi_pkg::KIND_STEP, 24'd0, 24'd0, 24'd0, 24'd65536));
    send_cmd(make_cmd(ppi_pkg::KIND_SET_VEL, 24'h7FFFFF, 24'h7FFFFF, 24'd0, 24'd0));
    repeat (300) send_cmd(make_cmd(ppi_pkg::KIND_STEP, 24'd0, 24'd0, 24'd0, 24'hFFFFFF));
    send_cmd(make_cmd(ppi_pkg::KIND_SET_VEL, 24'h800000, 24'h800000, 24'd0, 24'd0));
    repeat (600) send_cmd(make_cmd(ppi_pkg::KIND_STEP, 24'd0, 24'd0, 24'd0, 24'hFFFFFF));
  endtask

  task automatic test_random_traffic(input int n_items);
    int sent;
    int burst;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) < 8) begin
        // velocity command followed by a run of steps, unused fields carry noise
        send_cmd(make_cmd(ppi_pkg::KIND_SET_VEL, rand_vel(), rand_vel(), rand_vel(),
                          24'($urandom)));
        burst = $urandom_range(8, 1);
        repeat (burst) begin
          send_cmd(make_cmd(ppi_pkg::KIND_STEP, 24'($urandom), 24'($urandom),
                            24'($urandom), rand_step()));
        end
        sent += burst + 1;
      end else begin
        send_cmd(make_cmd(ppi_pkg::ppi_kind_e'($urandom_range(1)), 24'($urandom),
                          24'($urandom), 24'($urandom), 24'($urandom)));
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    // receiver holds off long enough for the block to fill and stall its input
    hold_seq++;
    test_random_traffic(40);
  endtask

  task automatic test_drain_pause();
    wait_drain();
    @(posedge clk_i);
  endtask

  // receiver side
  initial out_bus.ready = 1'b0;

  always @(posedge clk_i) begin
    out_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    pose_res_t want;
    if (rst_ni && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (pose_queue.size() == 0) begin
        $error("pose result with no pending expectation");
        mismatches++;
      end else begin
        want = pose_queue.pop_front();
        if (out_bus.pos_x !== want.pos_x) begin
          $error("pos_x: expected %0d, got %0d", $signed(want.pos_x), out_bus.pos_x);
          mismatches++;
        end
        if (out_bus.pos_y !== want.pos_y) begin
          $error("pos_y: expected %0d, got %0d", $signed(want.pos_y), out_bus.pos_y);
          mismatches++;
        end
        if (out_bus.heading !== want.heading) begin
          $error("heading: expected %0d, got %0d", want.heading, out_bus.heading);
          mismatches++;
        end
        if (out_bus.saturated !== want.saturated) begin
          $error("saturated: expected %0d, got %0d", want.saturated, out_bus.saturated);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #3ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    in_bus.valid     = 1'b0;
    in_bus.kind      = 1'b0;
    in_bus.lin_vel_x = '0;
    in_bus.lin_vel_y = '0;
    in_bus.turn_rate = '0;
    in_bus.step_time = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 25;
    recv_idle_pct = 77;
    test_reset_state();
    test_field_extremes();
    test_heading_wrap();
    test_random_traffic(200);
    test_backpressure();
    test_random_traffic(100);
    test_drain_pause();

    send_idle_pct = 77;
    recv_idle_pct = 25;
    test_random_traffic(300);
    test_drain_pause();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_saturation();
    test_random_traffic(250);

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pose_queue.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
